FILE: rtl/masked_max_filter_2d_unit_macros.svh
// Assertion macros for the masked max filter block.
// Included by the top level; no other dependencies.
`ifndef MASKED_MAX_FILTER_2D_UNIT_MACROS_SVH
`define MASKED_MAX_FILTER_2D_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define MMF_ASSERT_IMPL(label, clk, rstn, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define MMF_ASSERT_NEXT(label, clk, rstn, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);
`endif

FILE: rtl/mmf_pkg.sv
// Shared constants and types for the masked max filter block.
// No dependencies.
package mmf_pkg;
    localparam int MAX_SIDE   = 512;
    localparam int MAX_RADIUS = 3;
    localparam int PIXEL_BITS = 32;
    localparam int MASK_BITS  = 49;
    localparam int CFG_BITS   = 49;
    localparam int POS_BITS   = 9;
    localparam int SIDE_BITS  = 10;
    localparam int RAD_BITS   = 2;

    // configuration register indexes
    localparam logic [1:0] REG_SIDE   = 2'd0;
    localparam logic [1:0] REG_RADIUS = 2'd1;
    localparam logic [1:0] REG_MASK   = 2'd2;

    // row-store read request from the sequencer to the store
    typedef struct packed {
        logic        en;
        logic [15:0] addr;
    } rd_req_t;
endpackage

FILE: rtl/mmf_row_store.sv
// Row store: circular buffer of recent rows, one write and one read port.
// Depends on mmf_pkg.
module mmf_row_store #(
    parameter int DEPTH = 3584,
    parameter int AW    = 12,
    parameter int PB    = mmf_pkg::PIXEL_BITS
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [PB-1:0]        wdata,
    input  mmf_pkg::rd_req_t     rd,
    output logic [PB-1:0]        rdata
);
    logic [PB-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rdata <= mem[rd.addr[AW-1:0]];
        end
    end
endmodule

FILE: rtl/masked_max_filter_2d_unit.sv
// Top level of the masked max filter: config, sequencer and output queue.
// Depends on mmf_pkg, mmf_row_store and the assertion macro header.
// Each input pixel is written into the row store when accepted. Every
// output that it completes is then computed by reading the store one tap
// per cycle: one centre read, then a (2R+1)^2 scan of up to 49 tap reads.
// Each read is compared against the running maximum. No new pixel is
// accepted until the block is back in IDLE with no pending work. Each
// output goes through plan, scan, last fold and emit, an order set by
// the single read port of the store; an output stall holds emit.
// A one-entry output register holds a finished result while the next scan
// runs. No clearing pass follows reset; writes to the side, radius or mask
// register restart the frame at row 0, column 0.
`include "masked_max_filter_2d_unit_macros.svh"
module masked_max_filter_2d_unit #(
    parameter int MAX_SIDE   = mmf_pkg::MAX_SIDE,
    parameter int MAX_RADIUS = mmf_pkg::MAX_RADIUS,
    parameter int PIXEL_BITS = mmf_pkg::PIXEL_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [mmf_pkg::CFG_BITS-1:0] cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [PIXEL_BITS-1:0] s_pixel_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [PIXEL_BITS-1:0] m_out_value,
    output logic [mmf_pkg::POS_BITS-1:0] m_out_row,
    output logic [mmf_pkg::POS_BITS-1:0] m_out_col,
    output logic                         m_out_last_of_frame,
    output logic                         m_out_last_of_run
);
    localparam int ROWS  = 2 * MAX_RADIUS + 1;
    localparam int DEPTH = ROWS * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_SIDE);
    localparam int SW    = CW + 1;
    localparam int RW    = $clog2(ROWS);
    localparam int TW    = $clog2(ROWS * ROWS);
    localparam int PB    = mmf_pkg::POS_BITS;
    localparam int MB    = mmf_pkg::MASK_BITS;
    // reciprocal of ROWS, exact for every SW-bit row number
    localparam int     SLOT_K  = SW + RW + 1;
    localparam int     SLOT_PW = SW + SLOT_K + 1;
    localparam longint SLOT_M  = ((longint'(1) << SLOT_K) + ROWS - 1) / ROWS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PLAN = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_LAST = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    // configuration registers
    logic [mmf_pkg::SIDE_BITS-1:0] side_reg;
    logic [mmf_pkg::RAD_BITS-1:0]  rad_reg;
    logic [MB-1:0]                 mask_reg;
    logic                          cfg_hit;
    assign cfg_hit = cfg_we && (cfg_index == mmf_pkg::REG_SIDE ||
                     cfg_index == mmf_pkg::REG_RADIUS || cfg_index == mmf_pkg::REG_MASK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= 10'd512;
            rad_reg  <= 2'd1;
            mask_reg <= '1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mmf_pkg::REG_SIDE:   side_reg <= cfg_data[mmf_pkg::SIDE_BITS-1:0];
                mmf_pkg::REG_RADIUS: rad_reg  <= cfg_data[mmf_pkg::RAD_BITS-1:0];
                mmf_pkg::REG_MASK:   mask_reg <= cfg_data[MB-1:0];
                default: ;
            endcase
        end
    end

    // effective side and radius
    logic [SW-1:0] s_eff;
    logic [RW-1:0] r_eff;
    always_comb begin
        if (side_reg == '0) s_eff = SW'(1);
        else if (32'(side_reg) > MAX_SIDE) s_eff = SW'(MAX_SIDE);
        else s_eff = SW'(side_reg);
        if (32'(rad_reg) > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
        else r_eff = RW'(rad_reg);
    end

    logic [2:0]    state_reg, state_next;
    logic [SW-1:0] in_row_reg, in_col_reg;   // next input position
    logic [SW-1:0] r0_reg, r1_reg, c0_reg, c1_reg;
    logic [SW-1:0] orow_reg, ocol_reg;
    logic [RW:0]   dy_reg, dx_reg;
    logic [TW-1:0] bit_reg;
    logic          tap_vld_reg;              // read issued last cycle
    logic          first_reg;                // next read result is centre
    logic signed [PIXEL_BITS-1:0] best_reg;
    logic          ob_valid_reg;
    logic signed [PIXEL_BITS-1:0] ob_val_reg;
    logic [PB-1:0] ob_row_reg, ob_col_reg;
    logic          ob_lf_reg, ob_lr_reg;
    logic [PIXEL_BITS-1:0] rdata;
    mmf_pkg::rd_req_t rd;
    logic          have_pend_reg;
    logic          range_ok;

    assign s_ready = aresetn && (state_reg == ST_IDLE) && !have_pend_reg && !cfg_we;
    logic acc;
    assign acc = s_valid && s_ready;

    // position wraps at end of frame or when side shrank
    logic [SW-1:0] r_in, c_in;
    always_comb begin
        if (in_row_reg >= s_eff || in_col_reg >= s_eff) begin
            r_in = '0; c_in = '0;
        end else begin
            r_in = in_row_reg; c_in = in_col_reg;
        end
    end

    // row slot of a row number (row mod ROWS) by reciprocal multiply
    function automatic logic [RW-1:0] slot_of(input logic [SW-1:0] row);
        logic [SLOT_PW-1:0] prod;
        logic [SW-1:0]      quo;
        logic [SW-1:0]      rem;
        prod = SLOT_PW'(row) * SLOT_PW'(SLOT_M);
        quo  = prod[SLOT_K +: SW];
        rem  = row - SW'(32'(quo) * ROWS);
        return rem[RW-1:0];
    endfunction

    logic [AW-1:0] waddr;
    assign waddr = AW'(32'(slot_of(r_in)) * MAX_SIDE + 32'(c_in));

    // scan tap coordinates
    logic signed [SW+1:0] tr, tc;
    logic tap_in;
    assign tr = $signed({2'b0, orow_reg}) + $signed((SW+2)'(dy_reg)) - $signed((SW+2)'(r_eff));
    assign tc = $signed({2'b0, ocol_reg}) + $signed((SW+2)'(dx_reg)) - $signed((SW+2)'(r_eff));
    assign tap_in = !tr[SW+1] && tr < $signed({2'b0, s_eff}) && !tc[SW+1] &&
                    tc < $signed({2'b0, s_eff}) && 32'(bit_reg) < MB && mask_reg[bit_reg];
    logic [RW:0] wside;
    assign wside = {r_eff, 1'b1};
    logic [SW-1:0] tr_u, tc_u;
    assign tr_u = tr[SW-1:0];
    assign tc_u = tc[SW-1:0];

    always_comb begin
        rd.en   = 1'b0;
        rd.addr = '0;
        if (state_reg == ST_PLAN) begin
            rd.en   = 1'b1;
            rd.addr = 16'(32'(slot_of(orow_reg)) * MAX_SIDE + 32'(ocol_reg));
        end else if (state_reg == ST_SCAN && tap_in) begin
            rd.en   = 1'b1;
            rd.addr = 16'(32'(slot_of(tr_u)) * MAX_SIDE + 32'(tc_u));
        end
    end

    mmf_row_store #(.DEPTH(DEPTH), .AW(AW), .PB(PIXEL_BITS)) u_store (
        .aclk(aclk), .we(acc), .waddr(waddr), .wdata(PIXEL_BITS'(s_pixel_value)),
        .rd(rd), .rdata(rdata)
    );

    logic out_take;
    assign out_take = m_valid && m_ready;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            state_reg   <= ST_IDLE;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            tap_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tap_vld_reg <= rd.en;
            if (acc) begin
                if (c_in + SW'(1) >= s_eff) begin
                    in_col_reg <= '0;
                    in_row_reg <= (r_in + SW'(1) >= s_eff) ? '0 : r_in + SW'(1);
                end else begin
                    in_col_reg <= c_in + SW'(1);
                    in_row_reg <= r_in;
                end
                // output range completed by this pixel
                if (r_in == s_eff - SW'(1)) begin
                    r0_reg <= (r_in >= SW'(r_eff)) ? r_in - SW'(r_eff) : '0;
                    r1_reg <= s_eff - SW'(1);
                end else if (r_in >= SW'(r_eff)) begin
                    r0_reg <= r_in - SW'(r_eff); r1_reg <= r_in - SW'(r_eff);
                end else begin
                    r0_reg <= SW'(1); r1_reg <= '0;
                end
                if (c_in == s_eff - SW'(1)) begin
                    c0_reg <= (c_in >= SW'(r_eff)) ? c_in - SW'(r_eff) : '0;
                    c1_reg <= s_eff - SW'(1);
                end else if (c_in >= SW'(r_eff)) begin
                    c0_reg <= c_in - SW'(r_eff); c1_reg <= c_in - SW'(r_eff);
                end else begin
                    c0_reg <= SW'(1); c1_reg <= '0;
                end
            end
            if (state_reg == ST_IDLE && state_next == ST_PLAN) begin
                orow_reg <= r0_reg;
                ocol_reg <= c0_reg;
            end
            if (state_reg == ST_PLAN) begin
                dy_reg <= '0; dx_reg <= '0; bit_reg <= '0;
                first_reg <= 1'b1;
            end
            if (state_reg == ST_SCAN) begin
                if (dx_reg == wside - 1'b1) begin
                    dx_reg <= '0; dy_reg <= dy_reg + 1'b1;
                end else begin
                    dx_reg <= dx_reg + 1'b1;
                end
                bit_reg <= bit_reg + 1'b1;
            end
            // fold returned read data into the running maximum
            if (tap_vld_reg) begin
                first_reg <= 1'b0;
                if (first_reg || $signed(rdata) > best_reg) best_reg <= $signed(rdata);
            end
            if (state_reg == ST_EMIT && !ob_valid_reg) begin
                if (ocol_reg == c1_reg) begin
                    ocol_reg <= c0_reg; orow_reg <= orow_reg + 1'b1;
                end else begin
                    ocol_reg <= ocol_reg + 1'b1;
                end
            end
        end
    end

    logic scan_done, emit_last;
    assign scan_done = (dy_reg == wside - 1'b1) && (dx_reg == wside - 1'b1);
    assign emit_last = (orow_reg == r1_reg) && (ocol_reg == c1_reg);

    // an accepted pixel whose range is empty is dropped in IDLE
    assign range_ok = (r0_reg <= r1_reg) && (c0_reg <= c1_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (tap_vld_reg == 1'b0 && have_pend_reg && range_ok)
                         state_next = ST_PLAN;
            ST_PLAN: state_next = ST_SCAN;
            ST_SCAN: if (scan_done) state_next = ST_LAST;
            ST_LAST: state_next = ST_EMIT;
            ST_EMIT: if (!ob_valid_reg) state_next = emit_last ? ST_IDLE : ST_PLAN;
            default: state_next = ST_IDLE;
        endcase
    end

    // pending work flag: set when a pixel is accepted, cleared in IDLE
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            have_pend_reg <= 1'b0;
        end else if (acc) begin
            have_pend_reg <= 1'b1;
        end else if (state_reg == ST_IDLE) begin
            have_pend_reg <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            ob_valid_reg <= 1'b0;
        end else begin
            if (out_take) ob_valid_reg <= 1'b0;
            if (state_reg == ST_EMIT && !ob_valid_reg && range_ok) begin
                ob_valid_reg <= 1'b1;
                ob_val_reg   <= best_reg;
                ob_row_reg   <= orow_reg[PB-1:0];
                ob_col_reg   <= ocol_reg[PB-1:0];
                ob_lf_reg    <= (orow_reg == s_eff - SW'(1)) && (ocol_reg == s_eff - SW'(1));
                ob_lr_reg    <= emit_last;
            end
        end
    end

    assign m_valid             = ob_valid_reg;
    assign m_out_value         = ob_val_reg;
    assign m_out_row           = ob_row_reg;
    assign m_out_col           = ob_col_reg;
    assign m_out_last_of_frame = ob_lf_reg;
    assign m_out_last_of_run   = ob_lr_reg;

    // check terms
    logic chk_busy, chk_plan, chk_hold;
    assign chk_busy = state_reg != ST_IDLE;
    assign chk_plan = state_reg == ST_PLAN && !cfg_hit;
    assign chk_hold = m_valid && !m_ready && !cfg_hit;

    `MMF_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, chk_busy, !s_ready, "accept while busy")
    `MMF_ASSERT_NEXT(a_scan_reads, aclk, aresetn, chk_plan, state_reg == ST_SCAN, "no scan")
    `MMF_ASSERT_NEXT(a_hold, aclk, aresetn, chk_hold, m_valid && $stable(m_out_value), "held")
endmodule

FILE: tb/sv/tb_masked_max_filter_2d_unit.sv
// Self-checking testbench for masked_max_filter_2d_unit: random pixel frames,
// a predictor of the masked window maximum, and a scoreboard on the result port.
// Depends on mmf_pkg and the block RTL only.
`timescale 1ns / 1ps
module tb_masked_max_filter_2d_unit;
    import mmf_pkg::*;

    localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;
    localparam int STALL_LEN  = 400;
    localparam int WDOG_LIMIT = 20000;
    localparam int N_ITEMS    = 110;

    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] value;
        logic [POS_BITS-1:0]          row;
        logic [POS_BITS-1:0]          col;
        logic                         last_frame;
        logic                         last_run;
    } filt_out_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [1:0]                   cfg_index = REG_SIDE;
    logic [CFG_BITS-1:0]          cfg_data = '0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic signed [PIXEL_BITS-1:0] s_pixel_value = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic signed [PIXEL_BITS-1:0] m_out_value;
    logic [POS_BITS-1:0]          m_out_row;
    logic [POS_BITS-1:0]          m_out_col;
    logic                         m_out_last_of_frame;
    logic                         m_out_last_of_run;

    masked_max_filter_2d_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_pixel_value(s_pixel_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_value(m_out_value),
        .m_out_row(m_out_row), .m_out_col(m_out_col),
        .m_out_last_of_frame(m_out_last_of_frame), .m_out_last_of_run(m_out_last_of_run)
    );

    initial forever #5 aclk = ~aclk;

    // predictor state: recent rows, raster position and register copies
    logic [PIXEL_BITS-1:0] line_mem [STORE_ROWS*MAX_SIDE];
    int                    pos_row, pos_col;
    logic [SIDE_BITS-1:0]  side_reg;
    logic [RAD_BITS-1:0]   radius_reg;
    logic [MASK_BITS-1:0]  mask_reg;

    logic [PIXEL_BITS-1:0] pixel_q [$];
    filt_out_t             window_max_q [$];
    int n_items, n_results, n_errors, n_phases, dir_items;
    bit hold_req;

    function automatic logic signed [PIXEL_BITS-1:0] line_pixel(int r, int c);
        return line_mem[(r % STORE_ROWS) * MAX_SIDE + c];
    endfunction

    function automatic logic signed [PIXEL_BITS-1:0] masked_max(int orow, int ocol,
                                                               int s, int rad);
        logic signed [PIXEL_BITS-1:0] best;
        int w, rr, cc, bit_idx;
        best = line_pixel(orow, ocol);
        w = 2 * rad + 1;
        for (int dy = 0; dy < w; dy++) begin
            rr = orow + dy - rad;
            if (rr < 0 || rr >= s) continue;
            for (int dx = 0; dx < w; dx++) begin
                cc = ocol + dx - rad;
                bit_idx = dy * w + dx;
                if (cc < 0 || cc >= s || bit_idx >= MASK_BITS || !mask_reg[bit_idx]) continue;
                if (line_pixel(rr, cc) > best) best = line_pixel(rr, cc);
            end
        end
        return best;
    endfunction

    // store the accepted pixel and queue every output it completes
    function automatic void predict_pixel(logic [PIXEL_BITS-1:0] pix);
        int s, rad, r, c, r0, r1, c0, c1;
        filt_out_t o;
        s = (side_reg == 0) ? 1 : ((side_reg > MAX_SIDE) ? MAX_SIDE : int'(side_reg));
        rad = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
        r = pos_row;
        c = pos_col;
        if (r >= s || c >= s) begin
            r = 0;
            c = 0;
        end
        line_mem[(r % STORE_ROWS) * MAX_SIDE + c] = pix;
        if (r == s - 1) begin
            r0 = (r - rad < 0) ? 0 : r - rad; r1 = s - 1;
        end else if (r >= rad) begin
            r0 = r - rad; r1 = r0;
        end else begin
            r0 = 1; r1 = 0;
        end
        if (c == s - 1) begin
            c0 = (c - rad < 0) ? 0 : c - rad; c1 = s - 1;
        end else if (c >= rad) begin
            c0 = c - rad; c1 = c0;
        end else begin
            c0 = 1; c1 = 0;
        end
        for (int orow = r0; orow <= r1; orow++)
            for (int ocol = c0; ocol <= c1; ocol++) begin
                o.value = masked_max(orow, ocol, s, rad);
                o.row = POS_BITS'(orow);
                o.col = POS_BITS'(ocol);
                o.last_frame = (orow == s - 1 && ocol == s - 1);
                o.last_run = (orow == r1 && ocol == c1);
                window_max_q.push_back(o);
            end
        c++;
        if (c >= s) begin
            c = 0;
            r++;
            if (r >= s) r = 0;
        end
        pos_row = r;
        pos_col = c;
    endfunction

    // pixel driver: bursts of random length with random gaps
    int burst_left = 1, gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_pixel(s_pixel_value);
                n_items++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    s_valid <= 1'b1;
                    s_pixel_value <= pixel_q.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and scoreboard; receiver stall pattern with a long hold-off
    int hold_left = 0, cyc = 0;
    always @(posedge aclk) begin
        filt_out_t got, want;
        if (aresetn) begin
            cyc++;
            if (m_valid && m_ready) begin
                got = '{m_out_value, m_out_row, m_out_col, m_out_last_of_frame,
                        m_out_last_of_run};
                n_results++;
                if (window_max_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: unexpected beat val=%0d row=%0d col=%0d",
                                 got.value, got.row, got.col);
                end else begin
                    want = window_max_q.pop_front();
                    if (got !== want) begin
                        n_errors++;
                        if (n_errors <= 10) begin
                            $write("ERROR: exp val=%0d r=%0d c=%0d lf=%0b lr=%0b, ",
                                   want.value, want.row, want.col, want.last_frame,
                                   want.last_run);
                            $display("got val=%0d r=%0d c=%0d lf=%0b lr=%0b",
                                     got.value, got.row, got.col,
                                     got.last_frame, got.last_run);
                        end
                    end
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = STALL_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if ((cyc / 300) % 3 == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // watchdog on cycles without any accepted beat
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn)
            idle_cycles = 0;
        else if (++idle_cycles >= WDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pixel_q.size() > 0 || s_valid || window_max_q.size() > 0)
            @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_BITS-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_SIDE:   side_reg = val[SIDE_BITS-1:0];
            REG_RADIUS: radius_reg = val[RAD_BITS-1:0];
            default:    mask_reg = val[MASK_BITS-1:0];
        endcase
        pos_row = 0;
        pos_col = 0;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [PIXEL_BITS-1:0] rand_pixel();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return -$urandom_range(1, 50);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(int side, int rad, logic [MASK_BITS-1:0] mask, int n);
        wait_drained();
        write_reg(REG_MASK, CFG_BITS'(mask));
        write_reg(REG_SIDE, CFG_BITS'(side));
        write_reg(REG_RADIUS, CFG_BITS'(rad));
        n_phases++;
        for (int i = 0; i < n; i++) pixel_q.push_back(rand_pixel());
    endtask

    // stimulus sequence
    initial begin
        int side, frames, n, planned;
        bit hold_done;
        side_reg = MAX_SIDE;
        radius_reg = 1;
        mask_reg = '1;
        pos_row = 0;
        pos_col = 0;
        hold_done = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        // reset settings: first row of a wide frame completes nothing
        repeat (4) pixel_q.push_back(rand_pixel());
        // side zero acts as one pixel; empty mask
        run_phase(0, 3, '0, 3);
        // tiny frame, widest window, full mask, extreme pixels
        run_phase(3, 3, '1, 0);
        pixel_q.push_back(32'h8000_0000); pixel_q.push_back(32'h7FFF_FFFF);
        pixel_q.push_back(32'hFFFF_FFFF); pixel_q.push_back(32'h0);
        pixel_q.push_back(32'h8000_0001); pixel_q.push_back(32'h7FFF_FFFE);
        pixel_q.push_back(32'h5555_5555); pixel_q.push_back(32'hAAAA_AAAA);
        pixel_q.push_back(32'h8000_0000);
        // oversized side clamps to the maximum; radius zero, partial frame
        run_phase(1023, 0, '0, 6);
        run_phase(MAX_SIDE, 0, MASK_BITS'({$urandom, $urandom}), 3);
        wait_drained();
        dir_items = n_items;
        planned = n_items;
        // random frames: mostly whole frames, some cut short by a reconfigure;
        // the first one is a full 8x8 frame run under a long receiver hold-off
        while (planned < N_ITEMS) begin
            side = hold_done ? $urandom_range(2, 8) : 8;
            frames = $urandom_range(1, 2);
            n = (hold_done && $urandom_range(0, 4) == 0) ? $urandom_range(1, side * side - 1)
                                                         : frames * side * side;
            if (n > N_ITEMS - planned) n = N_ITEMS - planned;
            run_phase(side, $urandom_range(0, 3), MASK_BITS'({$urandom, $urandom}), n);
            planned += n;
            if (!hold_done) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
        end
        wait_drained();
        $display("Run: %0d pixels in %0d configurations, %0d results checked, %0d mismatches",
                 n_items, n_phases, n_results, n_errors);
        if (n_errors == 0 && window_max_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
